// File: src/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the streaming find and replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned LenW       = 4;
  localparam int unsigned PosW       = 3;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned MaxFindDef = 8;
  localparam int unsigned MaxReplDef = 8;

  typedef enum logic [CfgIdxW-1:0] {
    RegFindLen   = 4'd0,
    RegFindBytes = 4'd1,
    RegReplLen   = 4'd2,
    RegReplBytes = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            en;
    logic            shift;
    logic [PosW-1:0] pos;
  } cell_ctl_t;

endpackage

// File: src/sfr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cell
// One slot of the pending window: insert, compare and shift toward slot 0.
// ----------------------------------------------------------------------------
module sfr_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                       clk_i,
  input  sfr_pkg::cell_ctl_t         ctl_i,
  input  logic [sfr_pkg::ByteW-1:0]  in_byte_i,
  input  logic [sfr_pkg::ByteW-1:0]  next_i,
  input  logic [sfr_pkg::ByteW-1:0]  find_i,
  output logic [sfr_pkg::ByteW-1:0]  cur_o,
  output logic                       eq_o
);
  import sfr_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;

  assign cur_o  = (ctl_i.pos == PosW'(Idx)) ? in_byte_i : byte_q;
  assign eq_o   = (cur_o == find_i);
  assign byte_d = ctl_i.shift ? next_i : cur_o;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      byte_q <= byte_d;
    end
  end

endmodule

// File: src/sfr_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_emit
// Burst buffer that drains one result per cycle into the output register while that register is empty or being taken.
// ----------------------------------------------------------------------------
module sfr_emit #(
  parameter int unsigned Depth = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [Depth-1:0][sfr_pkg::ByteW-1:0] load_bytes_i,
  input  logic [sfr_pkg::LenW-1:0]          load_len_i,
  input  logic                              load_mark_i,
  input  logic                              load_eot_i,
  output logic                              can_load_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sfr_pkg::ByteW-1:0]         m_axis_tdata,  // out_byte
  output logic                              m_axis_tuser,  // has_byte
  output logic                              m_axis_tlast
);
  import sfr_pkg::*;

  logic [Depth-1:0][ByteW-1:0] buf_q, buf_d;
  logic [LenW-1:0]             len_q, len_d;
  logic                        mark_q, eot_q;
  logic                        ov_q;
  logic [ByteW-1:0]            ob_q;
  logic                        oh_q, ol_q;
  logic                        move;

  assign move       = (len_q != '0) && (!ov_q || m_axis_tready);
  assign can_load_o = (len_q == '0) || ((len_q == LenW'(1)) && move);

  always_comb begin
    buf_d = buf_q;
    len_d = len_q;
    if (move) begin
      for (int j = 0; j < Depth - 1; j++) begin
        buf_d[j] = buf_q[j+1];
      end
      len_d = len_q - LenW'(1);
    end
    if (load_i) begin
      buf_d = load_bytes_i;
      len_d = load_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (move) begin
      ob_q <= mark_q ? '0 : buf_q[0];
      oh_q <= !mark_q;
      ol_q <= eot_q && (len_q == LenW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      mark_q <= 1'b0;
      eot_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      len_q <= len_d;
      if (load_i) begin
        mark_q <= load_mark_i;
        eot_q  <= load_eot_i;
      end
      if (move) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ob_q;
  assign m_axis_tuser  = oh_q;
  assign m_axis_tlast  = ol_q;

endmodule

// File: src/stream_find_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find and replace over a byte stream with a window of cells.
// ----------------------------------------------------------------------------
// Each accepted byte enters a row of window cells that compare it against the
// pattern in the same cycle; every leftmost, non-overlapping match is replaced
// by the replacement bytes, other bytes pass through in order. An input byte
// that yields at most one result is taken every cycle while the output is not
// stalled. A byte that yields several results (a replacement, or the flush at
// end of text) occupies the burst buffer until all of them drain, so the
// next byte waits for that burst; the output register drains one result per
// cycle while m_axis_tready is high. With an empty pattern the text passes
// unchanged. A text whose final byte yields no result ends with a marker
// result (tuser low) that carries tlast. Write the configuration only while
// the block is idle; writing find_len drops any pending bytes.
// ----------------------------------------------------------------------------
module stream_find_replace #(
  parameter int unsigned MAX_FIND = sfr_pkg::MaxFindDef,
  parameter int unsigned MAX_REPL = sfr_pkg::MaxReplDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sfr_pkg::ByteW-1:0]    s_axis_tdata,   // in_byte
  input  logic                         s_axis_tlast,   // end_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sfr_pkg::ByteW-1:0]    m_axis_tdata,   // out_byte
  output logic                         m_axis_tuser,   // has_byte
  output logic                         m_axis_tlast    // last
);
  import sfr_pkg::*;

  localparam int unsigned BDepth = (MAX_FIND > MAX_REPL) ? MAX_FIND : MAX_REPL;

  logic [LenW-1:0]  find_len_q, repl_len_q;
  logic [CfgW-1:0]  find_bytes_q, repl_bytes_q;
  logic [PosW-1:0]  count_q, count_d;

  logic [LenW-1:0]  flen, rlen, len_after, burst_len;
  logic             accept, full, match, src_repl, mark;
  logic             cfg_wr;
  cell_ctl_t        ctl;

  logic [MAX_FIND-1:0][ByteW-1:0] cur;
  logic [MAX_FIND-1:0]            eq;
  logic [BDepth-1:0][ByteW-1:0]   burst_bytes;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_len_q   <= '0;
      find_bytes_q <= '0;
      repl_len_q   <= '0;
      repl_bytes_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        RegFindLen:   find_len_q   <= cfg_data_i[LenW-1:0];
        RegFindBytes: find_bytes_q <= cfg_data_i;
        RegReplLen:   repl_len_q   <= cfg_data_i[LenW-1:0];
        RegReplBytes: repl_bytes_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign flen = (find_len_q > LenW'(MAX_FIND)) ? LenW'(MAX_FIND) : find_len_q;
  assign rlen = (repl_len_q > LenW'(MAX_REPL)) ? LenW'(MAX_REPL) : repl_len_q;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign len_after = {1'b0, count_q} + LenW'(1);
  assign full      = (flen != '0) && (len_after == flen);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_FIND; i++) begin
      if ((LenW'(i) < flen) && !eq[i]) begin
        match = 1'b0;
      end
    end
  end

  assign ctl.en    = accept;
  assign ctl.shift = full && !match;
  assign ctl.pos   = count_q;

  for (genvar g = 0; g < MAX_FIND; g++) begin : g_cell
    logic [ByteW-1:0] nxt;
    if (g == MAX_FIND - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cur[g+1];
    end
    sfr_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .in_byte_i (s_axis_tdata),
      .next_i    (nxt),
      .find_i    (find_bytes_q[g*ByteW +: ByteW]),
      .cur_o     (cur[g]),
      .eq_o      (eq[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if ((flen == '0) || s_axis_tlast || (full && match)) begin
        count_d = '0;
      end else if (!full) begin
        count_d = len_after[PosW-1:0];
      end
    end
    if (cfg_wr && (cfg_reg_e'(cfg_index_i) == RegFindLen)) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    src_repl = 1'b0;
    if (flen == '0) begin
      burst_len = LenW'(1);
    end else if (full) begin
      if (match) begin
        src_repl  = 1'b1;
        burst_len = rlen;
      end else begin
        burst_len = s_axis_tlast ? flen : LenW'(1);
      end
    end else begin
      burst_len = s_axis_tlast ? len_after : '0;
    end
    mark = s_axis_tlast && (burst_len == '0);
    if (mark) begin
      burst_len = LenW'(1);
    end
  end

  always_comb begin
    for (int j = 0; j < BDepth; j++) begin
      burst_bytes[j] = '0;
      if (src_repl) begin
        if (j < MAX_REPL) begin
          burst_bytes[j] = repl_bytes_q[j*ByteW +: ByteW];
        end
      end else if (j < MAX_FIND) begin
        burst_bytes[j] = cur[j];
      end
    end
  end

  sfr_emit #(
    .Depth (BDepth)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .load_bytes_i  (burst_bytes),
    .load_len_i    (burst_len),
    .load_mark_i   (mark),
    .load_eot_i    (s_axis_tlast),
    .can_load_o    (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
